// ===== rtl/core/key_debounce_long_press_repeat_macros.svh =====
// Assertion macros shared by the key scanner checker.
`ifndef KEY_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH
`define KEY_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KDLPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KDLPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kdlpr_pkg.sv =====
// Package with types and constants of the key scanner.
`timescale 1ns / 1ps
`default_nettype none

package kdlpr_pkg;

    localparam int KEY_W    = 4;
    localparam int KNUM_W   = 3;
    localparam int HOLD_W   = 16;
    localparam int PHASE_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD    = 1'd1;

    // Register values after reset.
    localparam logic [HOLD_W-1:0]  LONG_PRESS_RESET = 16'd20;
    localparam logic [PHASE_W-1:0] REPEAT_RESET     = 8'd5;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_PRESS    = 2'd2,
        MODE_LONG     = 2'd3
    } t_mode;

    typedef struct packed {
        logic [HOLD_W-1:0]  long_press_ticks;
        logic [PHASE_W-1:0] repeat_period;
    } t_cfg;

    typedef struct packed {
        logic [KNUM_W-1:0] key_number;
        logic              long_flag;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/kdlpr_if.sv =====
// Valid/ready channel interfaces for key samples and key reports.
`timescale 1ns / 1ps
`default_nettype none

interface kdlpr_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_lines;

    modport source (output valid, output key_lines, input ready);
    modport sink   (input valid, input key_lines, output ready);
endinterface

interface kdlpr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_number;
    logic       long_flag;

    modport source (output valid, output key_number, output long_flag, input ready);
    modport sink   (input valid, input key_number, input long_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kdlpr_fsm.sv =====
// Key state machine: debounce, hold counting, long press and repeat reports.
`timescale 1ns / 1ps
`default_nettype none

module kdlpr_fsm
    import kdlpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [KEY_W-1:0]  i_key_lines,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    t_mode               r_mode,  n_mode;
    logic [KNUM_W-1:0]   r_held,  n_held;
    logic [HOLD_W-1:0]   r_hold,  n_hold;
    logic [PHASE_W-1:0]  r_phase, n_phase;

    logic [KNUM_W-1:0]   key;
    logic [HOLD_W-1:0]   hold_adv;
    logic [PHASE_W:0]    phase_inc;
    logic [PHASE_W-1:0]  phase_adv;
    logic                held_down;

    // Lowest-numbered pressed key, zero when none is down.
    always_comb begin
        if (!i_key_lines[0]) begin
            key = 3'd1;
        end else if (!i_key_lines[1]) begin
            key = 3'd2;
        end else if (!i_key_lines[2]) begin
            key = 3'd3;
        end else if (!i_key_lines[3]) begin
            key = 3'd4;
        end else begin
            key = 3'd0;
        end
    end

    // Debounce check of the latched key only.
    always_comb begin
        case (r_held)
            3'd1:    held_down = !i_key_lines[0];
            3'd2:    held_down = !i_key_lines[1];
            3'd3:    held_down = !i_key_lines[2];
            3'd4:    held_down = !i_key_lines[3];
            default: held_down = 1'b0;
        endcase
    end

    // Saturating hold count and the repeat phase that runs alongside it.
    assign hold_adv  = (r_hold == {HOLD_W{1'b1}}) ? r_hold : r_hold + 1'b1;
    assign phase_inc = {1'b0, r_phase} + 1'b1;
    assign phase_adv = (phase_inc >= {1'b0, i_cfg.repeat_period}) ?
                       '0 : phase_inc[PHASE_W-1:0];

    // Next state and report.
    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_hold   = r_hold;
        n_phase  = r_phase;
        o_result = '0;
        case (r_mode)
            MODE_IDLE: begin
                if (key != 3'd0) begin
                    n_held = key;
                    n_mode = MODE_DEBOUNCE;
                end
            end
            MODE_DEBOUNCE: begin
                if (held_down) begin
                    n_mode  = MODE_PRESS;
                    n_hold  = '0;
                    n_phase = '0;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_PRESS: begin
                n_hold  = hold_adv;
                n_phase = phase_adv;
                if (key == 3'd0) begin
                    n_mode              = MODE_IDLE;
                    o_result.key_number = r_held;
                end else if (hold_adv > i_cfg.long_press_ticks) begin
                    n_mode              = MODE_LONG;
                    o_result.key_number = r_held;
                    o_result.long_flag  = 1'b1;
                end
            end
            MODE_LONG: begin
                if (key == 3'd0) begin
                    n_mode = MODE_IDLE;
                end else begin
                    n_hold  = hold_adv;
                    n_phase = phase_adv;
                    if (phase_adv == '0) begin
                        o_result.key_number = r_held;
                        o_result.long_flag  = 1'b1;
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
        // A report without a key carries no long flag.
        if (o_result.key_number == 3'd0) begin
            o_result.long_flag = 1'b0;
        end
    end

    // State registers advance once per accepted scan tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= '0;
            r_hold  <= '0;
            r_phase <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_hold  <= n_hold;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/key_debounce_long_press_repeat.sv =====
// Top level of the key scanner with debounce, long press and auto-repeat.
//
//   Channel   Dir  Handshake      Payload
//   i_in      in   valid/ready    key_lines[3:0], active low
//   o_out     out  valid/ready    key_number[2:0], long_flag
//   i_cfg_*   in   write enable   index 0 long_press_ticks, 1 repeat_period
//
// Every accepted scan tick gives one report on o_out. One scan tick can be
// accepted every cycle while i_in.ready is high; the state update is a single
// registered step, and an output register plus one skid entry hold reports.
// i_in.ready drops only while both the output register and the skid entry
// are full. Synchronous active-low reset clears state and restores the
// register defaults.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press_repeat
    import kdlpr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    kdlpr_in_if.sink                   i_in,
    kdlpr_out_if.source                o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_result result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    accept;
    logic    take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks <= LONG_PRESS_RESET;
            r_cfg.repeat_period    <= REPEAT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg_wdata;
                REG_REPEAT_PERIOD:    r_cfg.repeat_period    <= i_cfg_wdata[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign take       = r_out_valid && o_out.ready;

    kdlpr_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_key_lines (i_in.key_lines),
        .i_cfg       (r_cfg),
        .o_result    (result)
    );

    // Output register with a one-entry skid buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!accept) begin
                r_out_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload of the output and skid registers.
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= result;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.key_number = r_out.key_number;
    assign o_out.long_flag  = r_out.long_flag;

endmodule

`default_nettype wire

// ===== rtl/core/kdlpr_checker.sv =====
// Port-level checks of the key scanner and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "key_debounce_long_press_repeat_macros.svh"

module kdlpr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_key_number,
    input wire logic       i_long_flag
);

    // A long report always names a key.
    `KDLPR_ASSERT_IMP(a_long_has_key, i_clk, i_rst_n, i_out_valid && i_long_flag, i_key_number != 3'd0, "long flag without a key")

    // Reported key numbers stay within the four keys.
    `KDLPR_ASSERT_IMP(a_key_range, i_clk, i_rst_n, i_out_valid, i_key_number <= 3'd4, "key number out of range")

    // Input back-pressure only happens while a report is waiting.
    `KDLPR_ASSERT_IMP(a_stall_has_output, i_clk, i_rst_n, !i_in_ready, i_out_valid, "input stalled with no pending report")

    // After an accepted scan tick, a report is always valid in the next cycle.
    `KDLPR_ASSERT_NXT(a_accept_reports, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "accepted transaction gave no report")

    // A stalled report holds its payload.
    `KDLPR_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_key_number) && $stable(i_long_flag), "stalled report changed")

endmodule

bind key_debounce_long_press_repeat kdlpr_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_key_number (o_out.key_number),
    .i_long_flag  (o_out.long_flag)
);

`default_nettype wire
